/* rtl/rwps_pkg.sv */
// rwps_pkg: shared types and fixed widths for the roulette wheel pair select unit.
// Depends on nothing; used by the controller, the datapath and the top level.
package rwps_pkg;

  localparam int RND_W = 16;
  localparam int FIT_IN_W = 16;
  localparam int IDX_OUT_W = 6;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_SELECT = 1'b1;

  typedef struct packed {
    logic load;
    logic capture;
    logic calc_total;
    logic calc_ta;
    logic calc_tb;
    logic step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
  } status_t;

endpackage

/* rtl/rwps_ram.sv */
// rwps_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module rwps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/rwps_datapath.sv */
// rwps_datapath: fitness store, running sum and maximum, thresholds and the weight walk.
// Depends on rwps_pkg and rwps_ram; driven by commands from rwps_ctrl.
module rwps_datapath #(
  parameter int POP_MAX = 64,
  parameter int FIT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rwps_pkg::cmd_t                  cmd,
  output rwps_pkg::status_t               status,
  input  logic                            cfg_we,
  input  logic                            cfg_data,
  input  logic                            first_of_set,
  input  logic [rwps_pkg::FIT_IN_W-1:0]   fitness_value,
  input  logic [rwps_pkg::RND_W-1:0]      random_a,
  input  logic [rwps_pkg::RND_W-1:0]      random_b,
  input  logic [rwps_pkg::IDX_OUT_W-1:0]  fallback_a,
  input  logic [rwps_pkg::IDX_OUT_W-1:0]  fallback_b,
  output logic [rwps_pkg::IDX_OUT_W-1:0]  parent_a_index,
  output logic [rwps_pkg::IDX_OUT_W-1:0]  parent_b_index
);

  localparam int IDX_W = (POP_MAX > 1) ? $clog2(POP_MAX) : 1;
  localparam int CNT_W = $clog2(POP_MAX + 1);
  localparam int SUM_W = FIT_BITS + CNT_W;
  localparam int PROD_W = rwps_pkg::RND_W + SUM_W;
  localparam logic [CNT_W-1:0] POP_CNT = CNT_W'(POP_MAX);

  logic                 max_mode;
  logic [CNT_W-1:0]     entry_count;
  logic [SUM_W-1:0]     raw_sum;
  logic [FIT_BITS-1:0]  max_seen;
  logic [rwps_pkg::RND_W-1:0]     rand_a;
  logic [rwps_pkg::RND_W-1:0]     rand_b;
  logic [rwps_pkg::IDX_OUT_W-1:0] pick_a;
  logic [rwps_pkg::IDX_OUT_W-1:0] pick_b;
  logic [SUM_W-1:0]     total;
  logic [SUM_W-1:0]     ta;
  logic [SUM_W-1:0]     tb;
  logic [CNT_W-1:0]     proc_cnt;
  logic [CNT_W-1:0]     proc_cnt_next;

  logic [FIT_BITS-1:0]  fit;
  logic [CNT_W-1:0]     base_cnt;
  logic [SUM_W-1:0]     base_sum;
  logic [FIT_BITS-1:0]  base_max;
  logic                 store_we;
  logic [FIT_BITS-1:0]  ram_q;
  logic [SUM_W-1:0]     top;
  logic [SUM_W-1:0]     total_next;
  logic [rwps_pkg::RND_W-1:0] rnd_sel;
  logic [PROD_W-1:0]    prod;
  logic [SUM_W-1:0]     thresh;
  logic [FIT_BITS-1:0]  w;
  logic [SUM_W-1:0]     w_ext;

  assign fit = FIT_BITS'(fitness_value);
  assign base_cnt = first_of_set ? '0 : entry_count;
  assign base_sum = first_of_set ? '0 : raw_sum;
  assign base_max = first_of_set ? '0 : max_seen;
  assign store_we = cmd.load && (base_cnt < POP_CNT);

  assign top = SUM_W'(entry_count) * SUM_W'(max_seen);
  assign total_next = max_mode ? raw_sum : ((top >= raw_sum) ? (top - raw_sum) : '0);

  assign rnd_sel = cmd.calc_ta ? rand_a : rand_b;
  assign prod = PROD_W'(rnd_sel) * PROD_W'(total);
  assign thresh = prod[PROD_W-1:rwps_pkg::RND_W];

  assign w = max_mode ? ram_q : ((max_seen >= ram_q) ? (max_seen - ram_q) : '0);
  assign w_ext = SUM_W'(w);

  assign proc_cnt_next = cmd.capture ? '0 : (cmd.step ? proc_cnt + 1'b1 : proc_cnt);

  assign status.walk_done = (proc_cnt == entry_count) || ((ta == '0) && (tb == '0));

  rwps_ram #(
    .WIDTH(FIT_BITS),
    .DEPTH(POP_MAX)
  ) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(base_cnt[IDX_W-1:0]),
    .wdata(fit),
    .raddr(proc_cnt_next[IDX_W-1:0]),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_mode <= 1'b1;
      entry_count <= '0;
      raw_sum <= '0;
      max_seen <= '0;
      proc_cnt <= '0;
    end else begin
      if (cfg_we) begin
        max_mode <= cfg_data;
      end
      if (cmd.load) begin
        if (base_cnt < POP_CNT) begin
          entry_count <= base_cnt + 1'b1;
          raw_sum <= base_sum + SUM_W'(fit);
          max_seen <= (fit > base_max) ? fit : base_max;
        end else begin
          entry_count <= base_cnt;
          raw_sum <= base_sum;
          max_seen <= base_max;
        end
      end
      proc_cnt <= proc_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rand_a <= random_a;
      rand_b <= random_b;
      pick_a <= fallback_a;
      pick_b <= fallback_b;
    end
    if (cmd.calc_total) begin
      total <= total_next;
    end
    if (cmd.calc_ta) begin
      ta <= thresh;
    end
    if (cmd.calc_tb) begin
      tb <= thresh;
    end
    if (cmd.step) begin
      if (ta != '0) begin
        if (w_ext >= ta) begin
          ta <= '0;
          pick_a <= rwps_pkg::IDX_OUT_W'(proc_cnt);
        end else begin
          ta <= ta - w_ext;
        end
      end
      if (tb != '0) begin
        if (w_ext >= tb) begin
          tb <= '0;
          pick_b <= rwps_pkg::IDX_OUT_W'(proc_cnt);
        end else begin
          tb <= tb - w_ext;
        end
      end
    end
    if (cmd.out_load) begin
      parent_a_index <= pick_a;
      parent_b_index <= pick_b;
    end
  end

  assert property (@(posedge clk) disable iff (rst) entry_count <= POP_CNT)
    else $error("entry count beyond store depth");
  assert property (@(posedge clk) disable iff (rst) cmd.step |-> proc_cnt < entry_count)
    else $error("walk step past last stored entry");
  assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> (ta <= $past(ta)) && (tb <= $past(tb)))
    else $error("threshold grew during walk");

endmodule

/* rtl/rwps_ctrl.sv */
// rwps_ctrl: sequencing state machine for loads, threshold setup, walk and result output.
// Depends on rwps_pkg; issues commands to rwps_datapath.
module rwps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                req_type,
  output logic                out_valid,
  input  logic                out_stall,
  input  rwps_pkg::status_t   status,
  output rwps_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOTAL,
    S_THRESH_A,
    S_THRESH_B,
    S_WALK,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_take;
  logic   slot_free;

  assign in_stall = (state != S_IDLE);
  assign in_take = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          if (req_type == rwps_pkg::REQ_SELECT) begin
            cmd.capture = 1'b1;
            state_next = S_TOTAL;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_TOTAL: begin
        cmd.calc_total = 1'b1;
        state_next = S_THRESH_A;
      end
      S_THRESH_A: begin
        cmd.calc_ta = 1'b1;
        state_next = S_THRESH_B;
      end
      S_THRESH_B: begin
        cmd.calc_tb = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        if (status.walk_done) begin
          state_next = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.out_load |-> slot_free)
    else $error("result overwrites a pending transaction");
  assert property (@(posedge clk) disable iff (rst) cmd.step |-> !status.walk_done)
    else $error("walk advanced after it finished");
  assert property (@(posedge clk) disable iff (rst) cmd.capture |=> state == S_TOTAL)
    else $error("select transaction did not start setup");
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.capture, cmd.calc_total, cmd.calc_ta, cmd.calc_tb, cmd.step}))
    else $error("conflicting datapath commands");

endmodule

/* rtl/roulette_wheel_pair_select_unit.sv */
// roulette_wheel_pair_select_unit: top level joining controller, datapath and fitness store.
// Load: no result. Select: S_TOTAL, S_THRESH_A, S_THRESH_B, S_WALK, S_DONE, then out_valid;
// the walk of at most POP_MAX entries reads one fitness per cycle from the single read port.
// Next transaction accepted once S_DONE loads the result, later while the result is stalled.
// Reset clears entry count, sum, maximum and result valid, and sets maximize mode;
// the fitness store is not cleared.
module roulette_wheel_pair_select_unit #(
  parameter int POP_MAX = 64,
  parameter int FIT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            maximize_mode,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            req_type,
  input  logic                            first_of_set,
  input  logic [rwps_pkg::FIT_IN_W-1:0]   fitness_value,
  input  logic [rwps_pkg::RND_W-1:0]      random_a,
  input  logic [rwps_pkg::RND_W-1:0]      random_b,
  input  logic [rwps_pkg::IDX_OUT_W-1:0]  fallback_a,
  input  logic [rwps_pkg::IDX_OUT_W-1:0]  fallback_b,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rwps_pkg::IDX_OUT_W-1:0]  parent_a_index,
  output logic [rwps_pkg::IDX_OUT_W-1:0]  parent_b_index
);

  rwps_pkg::cmd_t    cmd;
  rwps_pkg::status_t status;

  assign cfg_ready = 1'b1;

  rwps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rwps_datapath #(
    .POP_MAX (POP_MAX),
    .FIT_BITS(FIT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (maximize_mode),
    .first_of_set  (first_of_set),
    .fitness_value (fitness_value),
    .random_a      (random_a),
    .random_b      (random_b),
    .fallback_a    (fallback_a),
    .fallback_b    (fallback_b),
    .parent_a_index(parent_a_index),
    .parent_b_index(parent_b_index)
  );

endmodule
